// ===== src/cfpr_pkg.sv =====
// Shared types, constants and the CRC-16/X-25 byte update for the framed packet receiver.
// No dependencies.
package cfpr_pkg;

  localparam int unsigned LENGTH_LIMIT = 64;

  localparam logic [7:0]  SYNC1       = 8'hAA;
  localparam logic [7:0]  SYNC2       = 8'h55;
  localparam logic [7:0]  CMD_FORBID  = 8'h7F;
  localparam logic [7:0]  ACK_FLAG    = 8'h80;
  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'h8408;

  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_TDATA_W = 56;

  // configuration register indexes
  localparam logic REG_OWN_ADDR   = 1'b0;
  localparam logic REG_BCAST_ADDR = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_DEST    = 4'd2,
    PH_SRC     = 4'd3,
    PH_ID      = 4'd4,
    PH_CMD     = 4'd5,
    PH_LEN     = 4'd6,
    PH_PAYLOAD = 4'd7,
    PH_TRL_HI  = 4'd8,
    PH_TRL_LO  = 4'd9
  } phase_t;

  typedef enum logic [2:0] {
    VERD_DATA      = 3'd0,
    VERD_BCAST     = 3'd1,
    VERD_ACK_OK    = 3'd2,
    VERD_CRC_ERR   = 3'd3,
    VERD_ACK_MISS  = 3'd4,
    VERD_DUPLICATE = 3'd5
  } verdict_t;

  // result item, last field in the lowest bits once padded into tdata
  typedef struct packed {
    logic [5:0] payload_length;
    logic [7:0] command;
    logic [7:0] frame_id;
    logic [7:0] source_address;
    logic [7:0] dest_address;
    logic       forbidden_cmd;
    verdict_t   verdict;
    logic [7:0] payload_byte;
  } result_t;

  // reflected CRC update, one byte, LSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== src/crc_framed_packet_receiver.sv =====
// Framed packet receiver top level: sync hunt, address filter, header capture,
// payload streaming and CRC-16/X-25 verdict. Depends on cfpr_pkg.
//
// One received byte per item; an item is taken every cycle while the result side keeps up.
// The byte is registered in the input stage, then the frame state machine and a one-byte
// CRC update act on it and load the result register. A payload byte yields one result item
// (out_tuser 0), the low trailer byte yields the verdict item (out_tuser 1), all other bytes
// yield none. A stalled result register backs up the input only when the byte in flight
// has a result to deliver.
module crc_framed_packet_receiver (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [7:0]                         cfg_wdata,
  // input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [cfpr_pkg::IN_TDATA_W-1:0]    in_tdata,   // [7:0] rx_byte, [15:8] awaited_ack_cmd
  // result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] payload_byte, [10:8] verdict, [11] forbidden_cmd, [19:12] dest_address,
  // [27:20] source_address, [35:28] frame_id, [43:36] command, [49:44] payload_length
  output logic [cfpr_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                               out_tuser   // [0] kind
);

  // configuration registers
  logic [7:0] own_addr_r, bcast_addr_r;

  // input stage
  logic       s1_valid_r;
  logic [7:0] s1_byte_r, s1_await_r;

  // frame state
  cfpr_pkg::phase_t phase_r, phase_nxt;
  logic [5:0]  span_r, span_nxt;
  logic [7:0]  dest_r, dest_nxt;
  logic [7:0]  src_r, src_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  cmd_r, cmd_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  trl_hi_r, trl_hi_nxt;
  logic [7:0]  last_id_r, last_id_nxt;

  // result register
  logic                out_valid_r;
  logic                out_kind_r;
  cfpr_pkg::result_t   out_data_r;

  logic                res_valid;
  logic                res_kind;
  cfpr_pkg::result_t   res;
  logic [15:0]         crc_fed;
  logic                s1_adv;

  assign crc_fed = cfpr_pkg::crc_feed(crc_r, s1_byte_r);

  // item in stage 1 leaves when it has no result or the result register is free
  assign s1_adv    = s1_valid_r && (!res_valid || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_addr_r   <= 8'h00;
      bcast_addr_r <= 8'hFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfpr_pkg::REG_OWN_ADDR:   own_addr_r   <= cfg_wdata;
        cfpr_pkg::REG_BCAST_ADDR: bcast_addr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r  <= in_tdata[7:0];
      s1_await_r <= in_tdata[15:8];
    end
  end

  // result fields for the byte in stage 1
  always_comb begin
    res_valid          = 1'b0;
    res_kind           = 1'b0;
    res.payload_byte   = 8'h00;
    res.verdict        = cfpr_pkg::VERD_DATA;
    res.forbidden_cmd  = 1'b0;
    res.dest_address   = dest_r;
    res.source_address = src_r;
    res.frame_id       = id_r;
    res.command        = cmd_r;
    res.payload_length = len_r;
    if (s1_valid_r) begin
      if (phase_r == cfpr_pkg::PH_PAYLOAD) begin
        res_valid        = 1'b1;
        res.payload_byte = s1_byte_r;
      end else if (phase_r == cfpr_pkg::PH_TRL_LO) begin
        res_valid = 1'b1;
        res_kind  = 1'b1;
        if ({trl_hi_r, s1_byte_r} != ~crc_r) begin
          res.verdict = cfpr_pkg::VERD_CRC_ERR;
        end else begin
          res.forbidden_cmd = (cmd_r == cfpr_pkg::CMD_FORBID);
          priority if (dest_r == own_addr_r && cmd_r[7]) begin
            res.verdict = (cmd_r == (s1_await_r | cfpr_pkg::ACK_FLAG)) ?
                          cfpr_pkg::VERD_ACK_OK : cfpr_pkg::VERD_ACK_MISS;
          end else if (dest_r == bcast_addr_r) begin
            res.verdict = cfpr_pkg::VERD_BCAST;
          end else if (id_r != last_id_r || id_r == 8'h00) begin
            res.verdict = cfpr_pkg::VERD_DATA;
          end else begin
            res.verdict = cfpr_pkg::VERD_DUPLICATE;
          end
        end
      end
    end
  end

  // next frame state
  always_comb begin
    phase_nxt   = phase_r;
    span_nxt    = span_r;
    dest_nxt    = dest_r;
    src_nxt     = src_r;
    id_nxt      = id_r;
    cmd_nxt     = cmd_r;
    len_nxt     = len_r;
    crc_nxt     = crc_r;
    trl_hi_nxt  = trl_hi_r;
    last_id_nxt = last_id_r;
    unique case (phase_r)
      cfpr_pkg::PH_SYNC2: begin
        if (s1_byte_r == cfpr_pkg::SYNC2) begin
          crc_nxt   = crc_fed;
          phase_nxt = cfpr_pkg::PH_DEST;
        end else begin
          phase_nxt = cfpr_pkg::PH_HUNT;
        end
      end
      cfpr_pkg::PH_DEST: begin
        if (s1_byte_r == own_addr_r || s1_byte_r == bcast_addr_r) begin
          dest_nxt  = s1_byte_r;
          crc_nxt   = crc_fed;
          phase_nxt = cfpr_pkg::PH_SRC;
        end else begin
          phase_nxt = cfpr_pkg::PH_HUNT;
        end
      end
      cfpr_pkg::PH_SRC: begin
        src_nxt   = s1_byte_r;
        crc_nxt   = crc_fed;
        phase_nxt = cfpr_pkg::PH_ID;
      end
      cfpr_pkg::PH_ID: begin
        id_nxt    = s1_byte_r;
        crc_nxt   = crc_fed;
        phase_nxt = cfpr_pkg::PH_CMD;
      end
      cfpr_pkg::PH_CMD: begin
        cmd_nxt   = s1_byte_r;
        crc_nxt   = crc_fed;
        phase_nxt = cfpr_pkg::PH_LEN;
      end
      cfpr_pkg::PH_LEN: begin
        if (s1_byte_r < 8'(cfpr_pkg::LENGTH_LIMIT)) begin
          len_nxt   = s1_byte_r[5:0];
          span_nxt  = s1_byte_r[5:0];
          crc_nxt   = crc_fed;
          phase_nxt = (s1_byte_r[5:0] != 6'd0) ? cfpr_pkg::PH_PAYLOAD : cfpr_pkg::PH_TRL_HI;
        end else begin
          phase_nxt = cfpr_pkg::PH_HUNT;
        end
      end
      cfpr_pkg::PH_PAYLOAD: begin
        crc_nxt  = crc_fed;
        span_nxt = span_r - 6'd1;
        if (span_r == 6'd1) begin
          phase_nxt = cfpr_pkg::PH_TRL_HI;
        end
      end
      cfpr_pkg::PH_TRL_HI: begin
        trl_hi_nxt = s1_byte_r;
        phase_nxt  = cfpr_pkg::PH_TRL_LO;
      end
      cfpr_pkg::PH_TRL_LO: begin
        phase_nxt = cfpr_pkg::PH_HUNT;
        if (res.verdict == cfpr_pkg::VERD_DATA) begin
          last_id_nxt = id_r;
        end
      end
      default: begin
        // hunting; a rejected byte is never re-examined here
        if (s1_byte_r == cfpr_pkg::SYNC1) begin
          crc_nxt   = cfpr_pkg::crc_feed(cfpr_pkg::CRC_INIT, cfpr_pkg::SYNC1);
          phase_nxt = cfpr_pkg::PH_SYNC2;
        end else begin
          phase_nxt = cfpr_pkg::PH_HUNT;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= cfpr_pkg::PH_HUNT;
      span_r    <= 6'd0;
      dest_r    <= 8'h00;
      src_r     <= 8'h00;
      id_r      <= 8'h00;
      cmd_r     <= 8'h00;
      len_r     <= 6'd0;
      crc_r     <= cfpr_pkg::CRC_INIT;
      trl_hi_r  <= 8'h00;
      last_id_r <= 8'h00;
    end else if (s1_adv) begin
      phase_r   <= phase_nxt;
      span_r    <= span_nxt;
      dest_r    <= dest_nxt;
      src_r     <= src_nxt;
      id_r      <= id_nxt;
      cmd_r     <= cmd_nxt;
      len_r     <= len_nxt;
      crc_r     <= crc_nxt;
      trl_hi_r  <= trl_hi_nxt;
      last_id_r <= last_id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && res_valid) begin
      out_kind_r <= res_kind;
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {(cfpr_pkg::OUT_TDATA_W - $bits(cfpr_pkg::result_t))'(0), out_data_r};

endmodule

// ===== test/cfpr_checker.sv =====
// Scoreboard for the framed packet receiver: watches config writes and both streams,
// predicts every result item from the accepted bytes and compares field by field.
// Depends on cfpr_pkg for types, constants and the result layout.
module cfpr_checker
  import cfpr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [7:0]             cfg_wdata,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tuser,
  output int                     fail_count,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic    kind;
    result_t body;
  } rx_result_t;

  rx_result_t  expected_q[$];
  logic [7:0]  own_addr;
  logic [7:0]  bcast_addr;
  phase_t      ph;
  logic [6:0]  span_left;
  logic [7:0]  dst_q;
  logic [7:0]  src_q;
  logic [7:0]  id_q;
  logic [7:0]  cmd_q;
  logic [5:0]  len_q;
  logic [15:0] crc_acc;
  logic [7:0]  trl_hi;
  logic [7:0]  last_id;
  int          errs = 0;

  assign fail_count = errs;

  // reflected X-25 update, one input bit per step
  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = acc;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r  = {1'b0, r[15:1]} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    errs++;
    // keep the log readable if the block is badly broken
    if (errs <= 100) begin
      $display("[%0t] mismatch %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    end
  endtask

  task automatic absorb_byte(input logic [7:0] b, input logic [7:0] awaited);
    rx_result_t e;
    logic       hit;
    e   = '0;
    hit = 1'b0;
    case (ph)
      PH_SYNC2: begin
        if (b == SYNC2) begin
          crc_acc = crc_step(crc_acc, b);
          ph      = PH_DEST;
        end else begin
          ph = PH_HUNT;
        end
      end
      PH_DEST: begin
        if (b == own_addr || b == bcast_addr) begin
          dst_q   = b;
          crc_acc = crc_step(crc_acc, b);
          ph      = PH_SRC;
        end else begin
          ph = PH_HUNT;
        end
      end
      PH_SRC: begin
        src_q   = b;
        crc_acc = crc_step(crc_acc, b);
        ph      = PH_ID;
      end
      PH_ID: begin
        id_q    = b;
        crc_acc = crc_step(crc_acc, b);
        ph      = PH_CMD;
      end
      PH_CMD: begin
        cmd_q   = b;
        crc_acc = crc_step(crc_acc, b);
        ph      = PH_LEN;
      end
      PH_LEN: begin
        if (b < LENGTH_LIMIT) begin
          len_q     = b[5:0];
          span_left = b[6:0];
          crc_acc   = crc_step(crc_acc, b);
          ph        = (b == 8'h00) ? PH_TRL_HI : PH_PAYLOAD;
        end else begin
          ph = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        crc_acc   = crc_step(crc_acc, b);
        span_left = span_left - 7'd1;
        if (span_left == 7'd0) begin
          ph = PH_TRL_HI;
        end
        e.kind              = 1'b0;
        e.body.payload_byte = b;
        hit                 = 1'b1;
      end
      PH_TRL_HI: begin
        trl_hi = b;
        ph     = PH_TRL_LO;
      end
      PH_TRL_LO: begin
        ph     = PH_HUNT;
        e.kind = 1'b1;
        hit    = 1'b1;
        if ({trl_hi, b} != ~crc_acc) begin
          e.body.verdict = VERD_CRC_ERR;
        end else begin
          e.body.forbidden_cmd = (cmd_q == CMD_FORBID);
          if (dst_q == own_addr && cmd_q[7]) begin
            e.body.verdict = (cmd_q == (awaited | ACK_FLAG)) ? VERD_ACK_OK : VERD_ACK_MISS;
          end else if (dst_q == bcast_addr) begin
            e.body.verdict = VERD_BCAST;
          end else if (id_q != last_id || id_q == 8'h00) begin
            e.body.verdict = VERD_DATA;
            last_id        = id_q;
          end else begin
            e.body.verdict = VERD_DUPLICATE;
          end
        end
      end
      default: begin
        ph = PH_HUNT;
        if (b == SYNC1) begin
          crc_acc = crc_step(CRC_INIT, b);
          ph      = PH_SYNC2;
        end
      end
    endcase
    if (hit) begin
      e.body.dest_address   = dst_q;
      e.body.source_address = src_q;
      e.body.frame_id       = id_q;
      e.body.command        = cmd_q;
      e.body.payload_length = len_q;
      expected_q.push_back(e);
    end
  endtask

  task automatic check_result();
    rx_result_t want;
    result_t    got;
    got = result_t'(out_tdata[$bits(result_t)-1:0]);
    if (expected_q.size() == 0) begin
      report("result item with nothing pending", out_tdata, 0);
      return;
    end
    want = expected_q.pop_front();
    if (out_tuser != want.kind)
      report("kind", out_tuser, want.kind);
    if (got.payload_byte != want.body.payload_byte)
      report("payload_byte", got.payload_byte, want.body.payload_byte);
    if (got.verdict != want.body.verdict)
      report("verdict", got.verdict, want.body.verdict);
    if (got.forbidden_cmd != want.body.forbidden_cmd)
      report("forbidden_cmd", got.forbidden_cmd, want.body.forbidden_cmd);
    if (got.dest_address != want.body.dest_address)
      report("dest_address", got.dest_address, want.body.dest_address);
    if (got.source_address != want.body.source_address)
      report("source_address", got.source_address, want.body.source_address);
    if (got.frame_id != want.body.frame_id)
      report("frame_id", got.frame_id, want.body.frame_id);
    if (got.command != want.body.command)
      report("command", got.command, want.body.command);
    if (got.payload_length != want.body.payload_length)
      report("payload_length", got.payload_length, want.body.payload_length);
    if (out_tdata[OUT_TDATA_W-1:$bits(result_t)] != '0)
      report("tdata padding", out_tdata[OUT_TDATA_W-1:$bits(result_t)], 0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      own_addr   = 8'h00;
      bcast_addr = 8'hFF;
      ph         = PH_HUNT;
      span_left  = '0;
      dst_q      = '0;
      src_q      = '0;
      id_q       = '0;
      cmd_q      = '0;
      len_q      = '0;
      crc_acc    = CRC_INIT;
      trl_hi     = '0;
      last_id    = '0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_OWN_ADDR) own_addr = cfg_wdata;
        else bcast_addr = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        check_result();
      end
      if (in_tvalid && in_tready) begin
        absorb_byte(in_tdata[7:0], in_tdata[15:8]);
      end
    end
    pending <= expected_q.size();
  end

endmodule

// ===== test/tb_top.sv =====
// Top of the framed packet receiver testbench: clock, reset, config writes and byte stimulus.
// Prediction and comparison live in cfpr_checker; depends on cfpr_pkg and the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cfpr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic                   cfg_index  = 1'b0;
  logic [7:0]             cfg_wdata  = '0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   in_tready;
  logic                   out_tvalid;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;
  int                     fail_count;
  int                     pending;

  bit         tx_idle   = 1'b0;
  bit         rx_idle   = 1'b0;
  int         cycles    = 0;
  int         sent      = 0;
  logic [7:0] own_cur   = 8'h00;
  logic [7:0] bcast_cur = 8'hFF;

  crc_framed_packet_receiver i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cfpr_checker i_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result side back-pressure
  always @(posedge clk) begin
    if (rx_idle && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    out_tready <= 1'b1;
  end

  // stimulus-side frame check sequence, computed byte-wise for the trailer
  function automatic logic [15:0] fcs_update(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  task automatic push_item(input logic [7:0] b, input logic [7:0] awaited);
    if (tx_idle && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {awaited, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent++;
  endtask

  // stop sending and let every expected item come out, plus the pipeline depth
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one write strobe, then cfg_we is dropped before returning so writes never touch cfg_we twice in one edge
  task automatic cfg_write(input logic idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  // keep > 0 truncates the frame to that many bytes
  task automatic send_frame(input logic [7:0] dst, input logic [7:0] src, input logic [7:0] fid,
                            input logic [7:0] cmd, input logic [6:0] len,
                            input logic [7:0] awaited, input bit bad_fcs, input int keep);
    logic [7:0]  fb[$];
    logic [15:0] acc;
    int          n;
    fb = '{SYNC1, SYNC2, dst, src, fid, cmd, {1'b0, len}};
    if (len < LENGTH_LIMIT) begin
      repeat (len) fb.push_back(8'($urandom));
    end
    acc = CRC_INIT;
    foreach (fb[i]) acc = fcs_update(acc, fb[i]);
    acc = ~acc;
    if (bad_fcs) acc ^= 16'($urandom_range(1, 16'hFFFF));
    fb.push_back(acc[15:8]);
    fb.push_back(acc[7:0]);
    n = (keep > 0 && keep < fb.size()) ? keep : fb.size();
    for (int i = 0; i < n; i++) push_item(fb[i], awaited);
  endtask

  task automatic random_frame();
    logic [7:0] dst;
    logic [7:0] fid;
    logic [7:0] cmd;
    logic [7:0] aw;
    logic [6:0] len;
    int         r;
    aw = 8'($urandom);
    r  = $urandom_range(0, 9);
    dst = (r < 4) ? own_cur : (r < 7) ? bcast_cur : 8'($urandom);
    // small IDs make repeats, hence duplicates, common
    fid = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    r   = $urandom_range(0, 7);
    case (r)
      0, 1:    cmd = {1'b1, aw[6:0]};
      2:       cmd = CMD_FORBID;
      3:       cmd = 8'($urandom) | ACK_FLAG;
      default: cmd = 8'($urandom);
    endcase
    r = $urandom_range(0, 19);
    if (r < 14)       len = 7'($urandom_range(0, 6));
    else if (r < 18)  len = 7'($urandom_range(7, 24));
    else if (r == 18) len = 7'(LENGTH_LIMIT - 1);
    else              len = 7'($urandom_range(LENGTH_LIMIT, 127));
    send_frame(dst, 8'($urandom), fid, cmd, len, aw, $urandom_range(0, 7) == 0,
               ($urandom_range(0, 11) == 0) ? $urandom_range(1, 8) : 0);
  endtask

  task automatic run_traffic(input int target);
    int base;
    base = sent;
    while (sent - base < target) begin
      if ($urandom_range(0, 9) < 8) begin
        random_frame();
      end else begin
        repeat ($urandom_range(1, 6)) begin
          push_item(($urandom_range(0, 3) == 0) ? SYNC1 : 8'($urandom), 8'($urandom));
        end
      end
      if ($urandom_range(0, 29) == 0) drain();
    end
  endtask

  initial begin
    logic [7:0] own_v;
    logic [7:0] bcast_v;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sync byte repeated: the second one only breaks the pair
    push_item(SYNC1, 8'h00);
    push_item(SYNC1, 8'hFF);
    push_item(SYNC2, 8'h00);
    // empty data frame with the forbidden command and ID zero
    send_frame(8'h00, 8'hFF, 8'h00, CMD_FORBID, 7'd0, 8'h00, 1'b0, 0);
    // broadcast with a corrupted trailer
    send_frame(8'hFF, 8'h00, 8'hFF, ACK_FLAG, 7'd1, 8'hFF, 1'b1, 0);
    // length at the limit is dropped after the length byte
    send_frame(8'h00, 8'h11, 8'h22, 8'h33, 7'(LENGTH_LIMIT), 8'h7F, 1'b0, 7);

    for (int p = 0; p < 5; p++) begin
      case (p)
        0: begin own_v = 8'h3C; bcast_v = 8'hFF; end
        1: begin own_v = 8'hFF; bcast_v = 8'h00; end
        2: begin own_v = 8'h5A; bcast_v = 8'h5A; end
        3: begin own_v = 8'($urandom); bcast_v = 8'($urandom); end
        default: begin own_v = 8'h00; bcast_v = 8'hFF; end
      endcase
      drain();
      cfg_write(REG_OWN_ADDR, own_v);
      cfg_write(REG_BCAST_ADDR, bcast_v);
      own_cur   = own_v;
      bcast_cur = bcast_v;
      // first phase always idles on both sides, last phase runs flat out
      tx_idle = (p < 4) && ((p == 0) || ($urandom_range(0, 2) != 0));
      rx_idle = (p < 4) && ((p == 0) || ($urandom_range(0, 2) != 0));
      run_traffic(120);
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cfpr_pkg.sv
src/crc_framed_packet_receiver.sv
test/cfpr_checker.sv
test/tb_top.sv
